### src/tle_pkg.sv
// Terminal line editor package: key codes, command kinds and the command beat
// passed from the front end to the back end through the command queue.
// No dependencies.
`timescale 1ns / 1ps

package tle_pkg;

  // Item opcodes
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Terminal byte codes
  localparam logic [7:0] KEY_DELETE    = 8'd1;
  localparam logic [7:0] KEY_LEFT      = 8'd2;
  localparam logic [7:0] KEY_RIGHT     = 8'd3;
  localparam logic [7:0] KEY_BACKSPACE = 8'd8;
  localparam logic [7:0] KEY_NEWLINE   = 8'd10;
  localparam logic [7:0] KEY_ESC       = 8'd27;
  localparam logic [7:0] KEY_SPACE     = 8'd32;
  localparam logic [7:0] KEY_RUBOUT    = 8'd127;
  localparam logic [7:0] KEY_BRACKET   = 8'h5B; // '['
  localparam logic [7:0] KEY_THREE     = 8'h33; // '3'
  localparam logic [7:0] KEY_TILDE     = 8'h7E; // '~'
  localparam logic [7:0] KEY_CAP_C     = 8'h43; // 'C'
  localparam logic [7:0] KEY_CAP_D     = 8'h44; // 'D'

  // Decoded edit command
  typedef enum logic [2:0] {
    CMD_NOP   = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_BKSP  = 3'd3,
    CMD_DEL   = 3'd4,
    CMD_INS   = 3'd5,
    CMD_READ  = 3'd6
  } cmd_kind_e;

  // One queue beat: data is the inserted byte or the read index
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       clear; // empty the held line before the command
    logic       done;  // line_done value after this item
  } cmd_t;

endpackage

### src/tle_if.sv
// Handshake channels of the terminal line editor: item input and result output.
// Standalone; no package needed.
`timescale 1ns / 1ps

interface tle_item_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] key_byte;
  logic [7:0] read_index;

  modport source (output valid, output opcode, output key_byte, output read_index,
                  input ready);
  modport sink   (input valid, input opcode, input key_byte, input read_index,
                  output ready);
endinterface

interface tle_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] cursor_pos;
  logic [7:0] line_length;
  logic       line_done;
  logic [7:0] read_char;

  modport source (output valid, output cursor_pos, output line_length,
                  output line_done, output read_char, input ready);
  modport sink   (input valid, input cursor_pos, input line_length,
                  input line_done, input read_char, output ready);
endinterface

### src/tle_front.sv
// Front end: accepts items, tracks escape sequences and the held-line flag,
// and turns each item into one command beat. Uses tle_pkg and tle_item_if.
`timescale 1ns / 1ps

module tle_front (
  input  logic         clk_i,
  input  logic         rst_ni,
  tle_item_if.sink     item_i,
  input  logic         full_i,
  output logic         push_o,
  output tle_pkg::cmd_t cmd_o
);
  import tle_pkg::*;

  typedef enum logic [3:0] {
    ESC_IDLE    = 4'b0001,
    ESC_SEEN    = 4'b0010,
    ESC_BRACKET = 4'b0100,
    ESC_THREE   = 4'b1000
  } esc_e;

  esc_e esc_q, esc_d, phase;
  logic done_q, done_d;
  logic plain_go;

  // Plain byte meaning, with no sequence in progress
  function automatic cmd_kind_e plain_kind(input logic [7:0] c);
    cmd_kind_e k;
    if (c inside {KEY_BACKSPACE, KEY_RUBOUT}) k = CMD_BKSP;
    else if (c == KEY_DELETE)                 k = CMD_DEL;
    else if (c == KEY_LEFT)                   k = CMD_LEFT;
    else if (c == KEY_RIGHT)                  k = CMD_RIGHT;
    else if (c >= KEY_SPACE)                  k = CMD_INS;
    else                                      k = CMD_NOP;
    return k;
  endfunction

  assign item_i.ready = !full_i;
  assign push_o       = item_i.valid && !full_i;

  // Classify the item and work out the next decoder state
  always_comb begin
    esc_d      = esc_q;
    done_d     = done_q;
    phase      = esc_q;
    plain_go   = 1'b0;
    cmd_o.kind  = CMD_NOP;
    cmd_o.data  = item_i.key_byte;
    cmd_o.clear = 1'b0;
    cmd_o.done  = done_q;
    if (item_i.opcode == OP_READ) begin
      cmd_o.kind = CMD_READ;
      cmd_o.data = item_i.read_index;
    end else begin
      // a held line is emptied first, which also drops any sequence
      cmd_o.clear = done_q;
      phase       = done_q ? ESC_IDLE : esc_q;
      esc_d       = ESC_IDLE;
      done_d      = 1'b0;
      case (phase)
        ESC_SEEN: begin
          if (item_i.key_byte == KEY_BRACKET) esc_d = ESC_BRACKET;
          else plain_go = 1'b1;
        end
        ESC_BRACKET: begin
          if (item_i.key_byte == KEY_CAP_C)      cmd_o.kind = CMD_RIGHT;
          else if (item_i.key_byte == KEY_CAP_D) cmd_o.kind = CMD_LEFT;
          else if (item_i.key_byte == KEY_THREE) esc_d = ESC_THREE;
          else plain_go = 1'b1;
        end
        ESC_THREE: begin
          if (item_i.key_byte == KEY_TILDE) cmd_o.kind = CMD_DEL;
          else plain_go = 1'b1;
        end
        default: begin
          if (item_i.key_byte == KEY_ESC)          esc_d = ESC_SEEN;
          else if (item_i.key_byte == KEY_NEWLINE) done_d = 1'b1;
          else plain_go = 1'b1;
        end
      endcase
      // broken sequence: ESC and newline fall to ignored control bytes here
      if (plain_go) cmd_o.kind = plain_kind(item_i.key_byte);
      cmd_o.done = done_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q  <= ESC_IDLE;
      done_q <= 1'b0;
    end else if (push_o) begin
      esc_q  <= esc_d;
      done_q <= done_d;
    end
  end

endmodule

### src/tle_queue.sv
// Two-entry command queue between front end and back end.
// Uses tle_pkg for the command beat type.
`timescale 1ns / 1ps

module tle_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tle_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output tle_pkg::cmd_t cmd_o,
  output logic          empty_o
);
  import tle_pkg::*;

  localparam int Depth = 2;

  cmd_t                     slot_q [Depth];
  logic                     wr_ptr_q, rd_ptr_q;
  logic [$clog2(Depth):0]   cnt_q;

  assign full_o  = (cnt_q == ($clog2(Depth) + 1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  // payload slots
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### src/tle_back.sv
// Back end: owns the line store, cursor and length; carries out commands,
// shifting the tail one byte a cycle, and holds the result register.
// Uses tle_pkg and tle_result_if.
`timescale 1ns / 1ps

module tle_back #(
  parameter int LINE_LEN = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  tle_pkg::cmd_t cmd_i,
  output logic          pop_o,
  tle_result_if.source  result_o
);
  import tle_pkg::*;

  localparam int LW = $clog2(LINE_LEN);
  localparam int CW = (LW > 8) ? LW : 8;
  localparam logic [LW-1:0] LenMax = LW'(LINE_LEN - 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_DEL  = 5'b00100,
    ST_RD   = 5'b01000,
    ST_RESP = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [LW-1:0]   cur_q, cur_d, len_q, len_d;
  logic [LW-1:0]   ptr_q, ptr_d, dst_q, dst_d;
  logic            pend_q, pend_d;
  logic [7:0]      ch_q, ch_d;
  logic            hit_q, hit_d;
  logic            done_q, done_d;
  logic [7:0]      rc_q, rc_d;

  logic [7:0]      mem [LINE_LEN];
  logic [7:0]      rdata_q;
  logic            mem_we;
  logic [LW-1:0]   mem_wa, mem_ra;
  logic [7:0]      mem_wd;

  logic [LW-1:0]   eff_cur, eff_len;
  logic [CW-1:0]   idx_w, len_w, cur_w;
  logic            hit, out_free, load;
  logic            out_valid_q;
  logic [7:0]      out_cur_q, out_len_q, out_rc_q;
  logic            out_done_q;

  assign eff_cur  = cmd_i.clear ? '0 : cur_q;
  assign eff_len  = cmd_i.clear ? '0 : len_q;
  assign idx_w    = CW'(cmd_i.data);
  assign len_w    = CW'(len_q);
  assign cur_w    = CW'(cur_q);
  assign hit      = (idx_w < len_w);
  assign out_free = !out_valid_q || result_o.ready;

  // Command sequencer
  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    len_d   = len_q;
    ptr_d   = ptr_q;
    dst_d   = dst_q;
    pend_d  = pend_q;
    ch_d    = ch_q;
    hit_d   = hit_q;
    done_d  = done_q;
    rc_d    = rc_q;
    pop_o   = 1'b0;
    load    = 1'b0;
    mem_we  = 1'b0;
    mem_wa  = dst_q;
    mem_wd  = rdata_q;
    mem_ra  = ptr_q;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          done_d  = cmd_i.done;
          rc_d    = '0;
          pend_d  = 1'b0;
          cur_d   = eff_cur;
          len_d   = eff_len;
          state_d = ST_RESP;
          case (cmd_i.kind)
            CMD_LEFT:  if (eff_cur != '0) cur_d = eff_cur - 1'b1;
            CMD_RIGHT: if (eff_cur < eff_len) cur_d = eff_cur + 1'b1;
            CMD_BKSP: begin
              if (eff_cur != '0) begin
                cur_d   = eff_cur - 1'b1;
                ptr_d   = eff_cur - 1'b1;
                state_d = ST_DEL;
              end
            end
            CMD_DEL: begin
              if (eff_cur < eff_len) begin
                ptr_d   = eff_cur;
                state_d = ST_DEL;
              end
            end
            CMD_INS: begin
              if (eff_len < LenMax) begin
                ptr_d   = eff_len;
                ch_d    = cmd_i.data;
                state_d = ST_INS;
              end
            end
            CMD_READ: begin
              mem_ra  = idx_w[LW-1:0];
              hit_d   = hit;
              state_d = ST_RD;
            end
            default: ;
          endcase
        end
      end
      ST_RD: begin
        rc_d    = hit_q ? rdata_q : '0;
        state_d = ST_RESP;
      end
      // close the gap: store[i] = store[i+1], each byte read in the cycle before it is written
      ST_DEL: begin
        pend_d = 1'b0;
        mem_we = pend_q;
        if (({1'b0, ptr_q} + (LW + 1)'(1)) < {1'b0, len_q}) begin
          mem_ra = ptr_q + 1'b1;
          pend_d = 1'b1;
          dst_d  = ptr_q;
          ptr_d  = ptr_q + 1'b1;
        end else if (!pend_q) begin
          len_d   = len_q - 1'b1;
          state_d = ST_RESP;
        end
      end
      // open a gap: store[i] = store[i-1] from the end down, then the new byte
      ST_INS: begin
        pend_d = 1'b0;
        mem_we = pend_q;
        if (ptr_q > cur_q) begin
          mem_ra = ptr_q - 1'b1;
          pend_d = 1'b1;
          dst_d  = ptr_q;
          ptr_d  = ptr_q - 1'b1;
        end else if (!pend_q) begin
          mem_we  = 1'b1;
          mem_wa  = cur_q;
          mem_wd  = ch_q;
          cur_d   = cur_q + 1'b1;
          len_d   = len_q + 1'b1;
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Line store: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_q <= mem[mem_ra];
  end

  // Work registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cur_q   <= '0;
      len_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      len_q   <= len_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q  <= ptr_d;
    dst_q  <= dst_d;
    ch_q   <= ch_d;
    hit_q  <= hit_d;
    done_q <= done_d;
    rc_q   <= rc_d;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_cur_q  <= cur_w[7:0];
      out_len_q  <= len_w[7:0];
      out_done_q <= done_q;
      out_rc_q   <= rc_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.cursor_pos  = out_cur_q;
  assign result_o.line_length = out_len_q;
  assign result_o.line_done   = out_done_q;
  assign result_o.read_char   = out_rc_q;

endmodule

### src/terminal_line_editor.sv
// Terminal line editor top level: front end, command queue and back end.
// Uses tle_pkg, tle_if, tle_front, tle_queue and tle_back.
//
//   channel   dir  modport  beat
//   item_i    in   sink     opcode, key_byte, read_index
//   result_o  out  source   cursor_pos, line_length, line_done, read_char
//
// Back-end steps: a move, ignored byte or newline goes straight to the
// response state, a read passes through a read state first, and an insert or
// delete shifts the tail bytes before it responds; the line store has one read
// and one write port and moves one byte per cycle.
// Reset clears cursor, length, escape state and flags at once; the line store
// is not cleared and is only read below the length.
// The two-entry queue and result register let input and output stall apart.
`timescale 1ns / 1ps

module terminal_line_editor #(
  parameter int LINE_LEN = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tle_item_if.sink     item_i,
  tle_result_if.source result_o
);
  import tle_pkg::*;

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  tle_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  tle_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .empty_o (empty)
  );

  tle_back #(
    .LINE_LEN (LINE_LEN)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .cmd_i    (pop_cmd),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule

### src/tle_checker.sv
// Port-level checks for the terminal line editor, bound to the top level.
// Depends on terminal_line_editor and its channel interfaces.
`timescale 1ns / 1ps

module tle_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] cursor_pos_i,
  input logic [7:0] line_length_i,
  input logic       line_done_i,
  input logic [7:0] read_char_i
);

  logic       in_acc, out_acc;
  logic [2:0] open_q;
  logic       seen_q, last_done_q;
  logic [7:0] last_len_q;
  logic [7:0] len_step;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_acc  = out_valid_i && out_ready_i;
  assign len_step = line_length_i - last_len_q;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      seen_q      <= 1'b0;
      last_done_q <= 1'b0;
      last_len_q  <= '0;
    end else begin
      open_q <= open_q + {2'b00, in_acc} - {2'b00, out_acc};
      if (out_acc) begin
        seen_q      <= 1'b1;
        last_done_q <= line_done_i;
        last_len_q  <= line_length_i;
      end
    end
  end

  // no result beat while reset is held
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  // a stalled result keeps its beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cursor_pos_i) &&
    $stable(line_length_i) && $stable(line_done_i) && $stable(read_char_i))
    else $error("stalled result changed");

  // every result answers an accepted item; queue, back end and output hold four
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i |-> open_q != 3'd0) and (open_q <= 3'd4))
    else $error("result count does not match accepted items");

  // within one line the length moves by at most one per item
  a_len_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && seen_q && !last_done_q |->
    (len_step == 8'd0) || (len_step == 8'd1) || (len_step == 8'hFF))
    else $error("line length jumped");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (item_i.valid),
  .in_ready_i    (item_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .cursor_pos_i  (result_o.cursor_pos),
  .line_length_i (result_o.line_length),
  .line_done_i   (result_o.line_done),
  .read_char_i   (result_o.read_char)
);
